/* hdl/gcsa_pkg.sv */
package gcsa_pkg;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEF      = 256;
   localparam int GLYPH_BITS_DEF = 16;

   // Fixed field widths
   localparam int GLYPH_ID_W = 16;
   localparam int CHAR_W     = 8;
   localparam int CODE_W     = 8;
   localparam int FREE_W     = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;    // latch request fields, restart the scan
      logic scan_step;  // issue one slot read, advance the scan index
      logic commit;     // decide, update the table, load the response register
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic scan_last;  // scan index sits on the last slot
      logic out_busy;   // response register full and not taken this cycle
   } sts_type;

endpackage

/* hdl/gcsa_if.sv */
interface gcsa_req_if;
   logic                              valid;
   logic                              ready;
   logic [gcsa_pkg::GLYPH_ID_W-1:0]   glyph_id;
   logic                              has_char;
   logic [gcsa_pkg::CHAR_W-1:0]       char_low_byte;

   modport source (output valid, output glyph_id, output has_char, output char_low_byte,
                   input ready);
   modport sink   (input valid, input glyph_id, input has_char, input char_low_byte,
                   output ready);
endinterface

interface gcsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gcsa_pkg::CODE_W-1:0]   code;
   logic                          was_new;
   logic                          refused;
   logic [gcsa_pkg::FREE_W-1:0]   free_left;

   modport source (output valid, output code, output was_new, output refused,
                   output free_left, input ready);
   modport sink   (input valid, input code, input was_new, input refused,
                   input free_left, output ready);
endinterface

/* hdl/gcsa_ctrl.sv */
module gcsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gcsa_pkg::sts_type  sts,
   output gcsa_pkg::cmd_type  cmd
);

   gcsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcsa_pkg::ST_IDLE: begin
            if (req_valid) state_in = gcsa_pkg::ST_SCAN;
         end
         gcsa_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = gcsa_pkg::ST_DRAIN;
         end
         gcsa_pkg::ST_DRAIN: begin
            state_in = gcsa_pkg::ST_COMMIT;
         end
         gcsa_pkg::ST_COMMIT: begin
            if (!sts.out_busy) state_in = gcsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = gcsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         gcsa_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         gcsa_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         gcsa_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         gcsa_pkg::ST_COMMIT: begin
            cmd.commit = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hdl/gcsa_dpath.sv */
module gcsa_dpath #(
   parameter int SLOTS      = gcsa_pkg::SLOTS_DEF,
   parameter int GLYPH_BITS = gcsa_pkg::GLYPH_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic                             csr_wdata,
   input  logic [gcsa_pkg::GLYPH_ID_W-1:0]  glyph_id,
   input  logic                             has_char,
   input  logic [gcsa_pkg::CHAR_W-1:0]      char_low_byte,
   input  gcsa_pkg::cmd_type                cmd,
   output gcsa_pkg::sts_type                sts,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [gcsa_pkg::CODE_W-1:0]      rsp_code,
   output logic                             rsp_was_new,
   output logic                             rsp_refused,
   output logic [gcsa_pkg::FREE_W-1:0]      rsp_free_left
);

   localparam int IDX_W = $clog2(SLOTS);

   // Configuration
   logic cid_ff, cid_in;

   // Request capture
   logic [GLYPH_BITS-1:0]           key_ff, key_in, key_req;
   logic [gcsa_pkg::CHAR_W-1:0]     pref_ff, pref_in;

   // Scan
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [GLYPH_BITS-1:0]           rd_glyph_ff;
   logic                            found_ff, found_in;
   logic [IDX_W-1:0]                hit_idx_ff, hit_idx_in;
   logic                            free_found_ff, free_found_in;
   logic [IDX_W-1:0]                free_idx_ff, free_idx_in;
   logic                            hit;

   // Table state
   logic [GLYPH_BITS-1:0]           glyph_mem [SLOTS];
   logic [SLOTS-1:0]                used_ff, used_in;
   logic [IDX_W-1:0]                free_cnt_ff, free_cnt_in;

   // Decision
   logic                            pref_ok;
   logic                            alloc;
   logic [IDX_W-1:0]                alloc_idx;
   logic [IDX_W-1:0]                res_idx;
   logic                            res_refused;

   // Response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [gcsa_pkg::CODE_W-1:0]     code_ff, code_in;
   logic                            was_new_ff, was_new_in;
   logic                            refused_ff, refused_in;
   logic [gcsa_pkg::FREE_W-1:0]     free_left_ff, free_left_in;

   // glyph id reduced (or zero-extended) to the stored key width
   always_comb begin
      key_req = '0;
      for (int b = 0; b < GLYPH_BITS && b < gcsa_pkg::GLYPH_ID_W; b++) begin
         key_req[b] = glyph_id[b];
      end
   end

   // slot 0 holds glyph 0 by construction, never read from memory
   assign hit = used_ff[rd_idx_ff] &&
                ((rd_idx_ff == '0) ? (key_ff == '0) : (rd_glyph_ff == key_ff));

   assign pref_ok = (pref_ff != '0) && (32'(pref_ff) < SLOTS) &&
                    !used_ff[pref_ff[IDX_W-1:0]];

   always_comb begin
      alloc       = 1'b0;
      alloc_idx   = free_idx_ff;
      res_idx     = '0;
      res_refused = 1'b0;
      if (cid_ff) begin
         res_refused = 1'b1;
      end else if (found_ff) begin
         res_idx = hit_idx_ff;
      end else if (free_cnt_ff == '0) begin
         res_refused = 1'b1;
      end else if (pref_ok) begin
         alloc     = 1'b1;
         alloc_idx = pref_ff[IDX_W-1:0];
         res_idx   = pref_ff[IDX_W-1:0];
      end else if (free_found_ff) begin
         alloc   = 1'b1;
         res_idx = free_idx_ff;
      end else begin
         res_refused = 1'b1;
      end
   end

   always_comb begin
      cid_in        = csr_we ? csr_wdata : cid_ff;
      key_in        = key_ff;
      pref_in       = pref_ff;
      idx_in        = idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      used_in       = used_ff;
      free_cnt_in   = free_cnt_ff;

      if (cmd.capture) begin
         key_in        = key_req;
         pref_in       = has_char ? char_low_byte : glyph_id[gcsa_pkg::CHAR_W-1:0];
         idx_in        = '0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
      end

      if (cmd.scan_step) begin
         idx_in      = idx_ff + 1'b1;
         rd_valid_in = 1'b1;
         rd_idx_in   = idx_ff;
         if (!free_found_ff && (idx_ff != '0) && !used_ff[idx_ff]) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end
      end

      if (rd_valid_ff && !found_ff && hit) begin
         found_in   = 1'b1;
         hit_idx_in = rd_idx_ff;
      end

      if (cmd.commit && alloc) begin
         used_in[alloc_idx] = 1'b1;
         free_cnt_in        = free_cnt_ff - 1'b1;
      end
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   assign code_in      = cmd.commit ? gcsa_pkg::CODE_W'(res_idx) : code_ff;
   assign was_new_in   = cmd.commit ? alloc : was_new_ff;
   assign refused_in   = cmd.commit ? res_refused : refused_ff;
   assign free_left_in = cmd.commit ? gcsa_pkg::FREE_W'(free_cnt_in) : free_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cid_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         used_ff      <= SLOTS'(1);
         free_cnt_ff  <= IDX_W'(SLOTS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cid_ff       <= cid_in;
         rd_valid_ff  <= rd_valid_in;
         used_ff      <= used_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pref_ff       <= pref_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      code_ff       <= code_in;
      was_new_ff    <= was_new_in;
      refused_ff    <= refused_in;
      free_left_ff  <= free_left_in;
   end

   // Glyph store: one write port (allocation), one registered read port (scan)
   always_ff @(posedge clock) begin
      if (cmd.commit && alloc) begin
         glyph_mem[alloc_idx] <= key_ff;
      end
      rd_glyph_ff <= glyph_mem[idx_ff];
   end

   assign sts.scan_last = (idx_ff == IDX_W'(SLOTS - 1));
   assign sts.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = code_ff;
   assign rsp_was_new   = was_new_ff;
   assign rsp_refused   = refused_ff;
   assign rsp_free_left = free_left_ff;

endmodule

/* hdl/glyph_code_slot_allocator.sv */
// Channel   Dir  Handshake            Payload
// req_bus   in   valid/ready          glyph_id[15:0], has_char, char_low_byte[7:0]
// rsp_bus   out  valid/ready          code[7:0], was_new, refused, free_left[7:0]
// csr_*     in   csr_we (no ready)    csr_wdata = cid_mode
//
// One transaction at a time; the response time is set by the slot scan,
// which reads the glyph store once per cycle through its single read port.
// The response sits in an output register; the next request is taken
// while it waits, and that request stalls in commit until the response is taken.
// Reset (synchronous, active high): slot 0 held by glyph 0, SLOTS-1 free,
// cid_mode clear. Glyph store contents are not cleared; unused slots are
// masked by their used bits.
module glyph_code_slot_allocator #(
   parameter int SLOTS      = gcsa_pkg::SLOTS_DEF,
   parameter int GLYPH_BITS = gcsa_pkg::GLYPH_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_wdata,
   gcsa_req_if.sink      req_bus,
   gcsa_rsp_if.source    rsp_bus
);

   gcsa_pkg::cmd_type cmd;
   gcsa_pkg::sts_type sts;

   // sequencer: idle -> scan (SLOTS reads) -> drain (last compare) -> commit
   gcsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, scan logic, allocation decision and response register
   gcsa_dpath #(
      .SLOTS      (SLOTS),
      .GLYPH_BITS (GLYPH_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .glyph_id      (req_bus.glyph_id),
      .has_char      (req_bus.has_char),
      .char_low_byte (req_bus.char_low_byte),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_code      (rsp_bus.code),
      .rsp_was_new   (rsp_bus.was_new),
      .rsp_refused   (rsp_bus.refused),
      .rsp_free_left (rsp_bus.free_left)
   );

   // A refused transaction never carries a code or a new allocation
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.refused |-> !rsp_bus.was_new && (rsp_bus.code == '0))
      else $error("refused response carries a code or allocation");

   // Slot 0 is reserved and never handed out
   a_no_slot0: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.was_new |-> (rsp_bus.code != '0))
      else $error("reserved slot allocated");

   // Only one request in flight: no accept right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("second request accepted during a scan");

   // Commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.scan_step, cmd.commit}))
      else $error("overlapping controller commands");

endmodule
